@@ rtl/core/cbqlp_pkg.sv @@
// Shared types, constants and coefficient table of the calibrated biquad lowpass.
package cbqlp_pkg;

    localparam int CH_W             = 2;
    localparam int CAL_CHANNELS     = 4;
    localparam int NUM_CHANNELS_DEF = 4;
    localparam int SAMPLE_BITS_DEF  = 12;
    localparam int SLOW_CUTOFF      = 0;
    localparam int WORD_W           = 32;
    localparam int OUT_W            = 16;
    localparam int FRAC_BITS        = 16;
    localparam int CFG_IDX_W        = 4;
    localparam int CFG_REG_COUNT    = 2 * CAL_CHANNELS;
    localparam int PROD_W           = 2 * WORD_W + 1;
    localparam int ACC_W            = 2 * WORD_W + 3;
    localparam int COEF_SHIFT       = 30;

    localparam logic signed [WORD_W-1:0] GAIN_RESET = 32'sd65536;

    typedef enum logic [2:0] {
        TAP_X0,
        TAP_X1,
        TAP_X2,
        TAP_Y1,
        TAP_Y2
    } t_tap;

    typedef struct packed {
        logic load;
        logic cal_mul;
        logic cal_add;
        logic mac_mul;
        logic acc_clear;
        logic acc_add;
        logic finish;
        logic out_load;
        t_tap tap;
    } t_dp_cmd;

    // Q2.30 coefficients; feedback taps are stored negated so every tap accumulates
    function automatic logic signed [WORD_W-1:0] coef(input t_tap tap);
        logic signed [WORD_W-1:0] c;
        case (tap)
            TAP_X0:  c = (SLOW_CUTOFF != 0) ? 32'sd25694       : 32'sd133697513;
            TAP_X1:  c = (SLOW_CUTOFF != 0) ? 32'sd51387       : 32'sd267395026;
            TAP_X2:  c = (SLOW_CUTOFF != 0) ? 32'sd25694       : 32'sd133697513;
            TAP_Y1:  c = (SLOW_CUTOFF != 0) ? 32'sd2132576163  : 32'sd842325263;
            TAP_Y2:  c = (SLOW_CUTOFF != 0) ? -32'sd1058937114 : -32'sd303373490;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/calibrated_biquad_lowpass_4ch.sv @@
// Top level of the four-channel calibrated second-order lowpass filter.
//
// Input stream: s_axis_tuser carries the channel, s_axis_tdata the raw
// converter sample in its low SAMPLE_BITS bits. Each request is calibrated
// with that channel's gain and offset, filtered by a direct-form-I biquad
// and returned on the output stream as volts times ten, saturated to 16 bits,
// with the channel echoed on m_axis_tuser.
// Configuration: one write channel, always ready; index 2*c is the gain and
// 2*c+1 the offset of channel c (signed Q16.16), other indexes are dropped.
// Write it only while no request is in flight.
// Sequence: calibration multiply, calibration add, five filter taps, last
// add, finish, output load. A request is taken only in idle; the single
// shared multiplier takes one calibration product and five filter taps in turn.
// The output register lets the next request in while a result waits; when
// the receiver stalls longer, the finished request holds in the sequencer and
// s_axis_tready stays low until the output register frees up.
// Reset: gains return to 1.0, offsets and all filter history to zero, and
// both streams empty.
module calibrated_biquad_lowpass_4ch
    import cbqlp_pkg::*;
#(
    parameter int  NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int  SAMPLE_BITS  = SAMPLE_BITS_DEF,
    localparam int S_TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // raw_sample in the low bits, upper bits ignored
    input  logic [CH_W-1:0]      s_axis_tuser,   // channel
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata,   // filtered_tenths
    output logic [CH_W-1:0]      m_axis_tuser,   // out_channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    cbqlp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    cbqlp_dp #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_channel         (s_axis_tuser),
        .i_raw_sample      (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_out_channel     (m_axis_tuser),
        .o_filtered_tenths (m_axis_tdata)
    );

endmodule

@@ rtl/core/cbqlp_ctrl.sv @@
// Sequencer for the calibrated biquad: steps the shared multiplier and owns the handshakes.
module cbqlp_ctrl
    import cbqlp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAL_MUL,
        ST_CAL_ADD,
        ST_MAC,
        ST_MAC_LAST,
        ST_FINISH,
        ST_OUT
    } t_state;

    t_state r_state, n_state;
    t_tap   r_tap, n_tap;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        o_cmd           = '0;
        o_cmd.tap       = r_tap;
        o_cmd.load      = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.cal_mul   = (r_state == ST_CAL_MUL);
        o_cmd.cal_add   = (r_state == ST_CAL_ADD);
        o_cmd.mac_mul   = (r_state == ST_MAC);
        o_cmd.acc_clear = (r_state == ST_MAC) && (r_tap == TAP_X0);
        o_cmd.acc_add   = ((r_state == ST_MAC) && (r_tap != TAP_X0)) ||
                          (r_state == ST_MAC_LAST);
        o_cmd.finish    = (r_state == ST_FINISH);
        o_cmd.out_load  = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);
    end

    always_comb begin
        n_state = r_state;
        n_tap   = r_tap;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CAL_MUL;
                end
            end
            ST_CAL_MUL: n_state = ST_CAL_ADD;
            ST_CAL_ADD: begin
                n_state = ST_MAC;
                n_tap   = TAP_X0;
            end
            ST_MAC: begin
                if (r_tap == TAP_Y2) begin
                    n_state = ST_MAC_LAST;
                end else begin
                    n_tap = t_tap'(r_tap + 3'd1);
                end
            end
            ST_MAC_LAST: n_state = ST_FINISH;
            ST_FINISH:   n_state = ST_OUT;
            ST_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tap       <= TAP_X0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tap       <= n_tap;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/core/cbqlp_dp.sv @@
// Datapath: calibration registers, per-channel delay line, shared multiplier and accumulator.
module cbqlp_dp
    import cbqlp_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    input  logic [CH_W-1:0]        i_channel,
    input  logic [SAMPLE_BITS-1:0] i_raw_sample,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [WORD_W-1:0]      i_cfg_data,
    output logic [CH_W-1:0]        o_out_channel,
    output logic [OUT_W-1:0]       o_filtered_tenths
);

    localparam int ST_DEPTH  = (NUM_CHANNELS < CAL_CHANNELS) ? NUM_CHANNELS : CAL_CHANNELS;
    localparam int ST_IDX_W  = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;
    localparam int LIM_W     = 5;
    localparam int MUL_A_W   = WORD_W + 1;
    localparam int TEN_W     = WORD_W + 4;
    localparam int OFFSET_BIT = 0;

    localparam logic [LIM_W-1:0] NUM_CH_LIM = LIM_W'(NUM_CHANNELS);
    localparam logic [CFG_IDX_W-1:0] CFG_LIM = CFG_IDX_W'(CFG_REG_COUNT);
    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    logic signed [WORD_W-1:0] r_gain   [CAL_CHANNELS];
    logic signed [WORD_W-1:0] r_offset [CAL_CHANNELS];
    logic signed [WORD_W-1:0] r_x1 [ST_DEPTH];
    logic signed [WORD_W-1:0] r_x2 [ST_DEPTH];
    logic signed [WORD_W-1:0] r_y1 [ST_DEPTH];
    logic signed [WORD_W-1:0] r_y2 [ST_DEPTH];

    logic [CH_W-1:0]          r_ch;
    logic [SAMPLE_BITS-1:0]   r_raw;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [WORD_W-1:0] r_x;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [WORD_W-1:0] r_y;
    logic [CH_W-1:0]          r_out_ch;
    logic [OUT_W-1:0]         r_out_tenths;

    logic                     ch_ok;
    logic [ST_IDX_W-1:0]      st_idx;
    logic signed [WORD_W-1:0] coef_w;
    logic signed [WORD_W-1:0] operand;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [WORD_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [ACC_W-1:0]  cal_sum;
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [WORD_W-1:0] x_new;
    logic signed [WORD_W-1:0] y_new;
    logic signed [TEN_W-1:0]  y_ext;
    logic signed [TEN_W-1:0]  tenths;
    logic [OUT_W-1:0]         tenths_sat;
    logic                     cfg_hit;
    logic [CH_W-1:0]          cfg_ch;

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-WORD_W:0] hi;
        hi = v[ACC_W-1:WORD_W-1];
        if ((&hi) || !(|hi)) begin
            return v[WORD_W-1:0];
        end
        return v[ACC_W-1] ? WORD_MIN : WORD_MAX;
    endfunction

    assign ch_ok  = (LIM_W'(r_ch) < NUM_CH_LIM);
    assign st_idx = r_ch[ST_IDX_W-1:0];
    assign coef_w = coef(i_cmd.tap);

    always_comb begin
        case (i_cmd.tap)
            TAP_X0:  operand = r_x;
            TAP_X1:  operand = r_x1[st_idx];
            TAP_X2:  operand = r_x2[st_idx];
            TAP_Y1:  operand = r_y1[st_idx];
            TAP_Y2:  operand = r_y2[st_idx];
            default: operand = r_x;
        endcase

        if (i_cmd.cal_mul) begin
            mul_a = $signed({{(MUL_A_W-SAMPLE_BITS){1'b0}}, r_raw});
            mul_b = r_gain[r_ch];
        end else begin
            mul_a = {coef_w[WORD_W-1], coef_w};
            mul_b = operand;
        end
    end

    assign mul_p   = mul_a * mul_b;
    assign cal_sum = ACC_W'(r_prod) + ACC_W'(r_offset[r_ch]);
    assign acc_sum = r_acc + ACC_W'(r_prod);
    assign x_new   = sat_word(cal_sum);
    // arithmetic shift rounds toward minus infinity
    assign y_new   = sat_word(r_acc >>> COEF_SHIFT);

    // y * 10 as shift-add
    assign y_ext  = TEN_W'(r_y);
    assign tenths = (y_ext <<< 3) + (y_ext <<< 1);

    always_comb begin
        if (!ch_ok || tenths <= 0) begin
            tenths_sat = '0;
        end else if (|tenths[TEN_W-1:OUT_W+FRAC_BITS]) begin
            tenths_sat = '1;
        end else begin
            tenths_sat = tenths[OUT_W+FRAC_BITS-1:FRAC_BITS];
        end
    end

    assign cfg_hit = i_cfg_we && (i_cfg_index < CFG_LIM);
    assign cfg_ch  = i_cfg_index[CH_W:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CAL_CHANNELS; i++) begin
                r_gain[i]   <= GAIN_RESET;
                r_offset[i] <= '0;
            end
            for (int i = 0; i < ST_DEPTH; i++) begin
                r_x1[i] <= '0;
                r_x2[i] <= '0;
                r_y1[i] <= '0;
                r_y2[i] <= '0;
            end
        end else begin
            if (cfg_hit) begin
                if (i_cfg_index[OFFSET_BIT]) begin
                    r_offset[cfg_ch] <= i_cfg_data;
                end else begin
                    r_gain[cfg_ch] <= i_cfg_data;
                end
            end
            // advance the delay line only for channels that have state
            if (i_cmd.finish && ch_ok) begin
                r_x2[st_idx] <= r_x1[st_idx];
                r_x1[st_idx] <= r_x;
                r_y2[st_idx] <= r_y1[st_idx];
                r_y1[st_idx] <= y_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch  <= i_channel;
            r_raw <= i_raw_sample;
        end
        if (i_cmd.cal_mul || i_cmd.mac_mul) begin
            r_prod <= mul_p;
        end
        if (i_cmd.cal_add) begin
            r_x <= x_new;
        end
        if (i_cmd.acc_clear) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= acc_sum;
        end
        if (i_cmd.finish) begin
            r_y <= y_new;
        end
        if (i_cmd.out_load) begin
            r_out_ch     <= r_ch;
            r_out_tenths <= tenths_sat;
        end
    end

    assign o_out_channel     = r_out_ch;
    assign o_filtered_tenths = r_out_tenths;

endmodule

@@ rtl/core/cbqlp_chk.sv @@
// Port-level checks for the calibrated biquad lowpass, bound to the top level.
module cbqlp_chk
    import cbqlp_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic [CH_W-1:0]  m_axis_tuser
);

    // reset empties the output and reopens the input
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("output not empty or input not ready after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed or dropped");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a request was taken");

    // a new result appears as the sequencer returns to idle
    a_result_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result raised while the sequencer is still busy");

endmodule

bind calibrated_biquad_lowpass_4ch cbqlp_chk u_cbqlp_chk (.*);

@@ tb/calibrated_biquad_lowpass_4ch_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the four-channel calibrated biquad lowpass filter.
module calibrated_biquad_lowpass_4ch_tb;
    import cbqlp_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RAW_W        = SAMPLE_BITS_DEF;
    localparam int S_TDATA_W    = ((RAW_W + 7) / 8) * 8;
    localparam int PAD_W        = S_TDATA_W - RAW_W;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 176;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int COEF_SET     = (SLOW_CUTOFF != 0) ? 1 : 0;

    localparam longint WORD_MAX   = 64'sd2147483647;
    localparam longint WORD_MIN   = -64'sd2147483648;
    localparam longint TENTHS_MAX = (64'sd1 << OUT_W) - 1;

    // b0, b1, b2, a1, a2 in Q2.30, indexed by tap; the set for SLOW_CUTOFF == 0 first
    localparam longint FILT_COEF [2][5] = '{
        '{133697513, 267395026, 133697513, -842325263, 303373490},
        '{25694, 51387, 25694, -2132576163, 1058937114}
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_CH0,
        REG_OFFSET_CH0,
        REG_GAIN_CH1,
        REG_OFFSET_CH1,
        REG_GAIN_CH2,
        REG_OFFSET_CH2,
        REG_GAIN_CH3,
        REG_OFFSET_CH3,
        REG_UNMAPPED
    } t_cal_reg;

    typedef struct {
        logic [CH_W-1:0]      channel;
        logic [S_TDATA_W-1:0] word;
    } t_sample;

    typedef struct {
        logic [CH_W-1:0]  channel;
        logic [OUT_W-1:0] tenths;
    } t_tenths;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [CH_W-1:0]      s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic [CH_W-1:0]      m_axis_tuser;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [WORD_W-1:0]    i_cfg_data    = '0;

    t_sample sample_q [$];
    t_tenths tenths_q [$];

    logic signed [WORD_W-1:0] cal_gain   [CAL_CHANNELS];
    logic signed [WORD_W-1:0] cal_offset [CAL_CHANNELS];
    logic signed [WORD_W-1:0] hist_x1    [NUM_CHANNELS_DEF];
    logic signed [WORD_W-1:0] hist_x2    [NUM_CHANNELS_DEF];
    logic signed [WORD_W-1:0] hist_y1    [NUM_CHANNELS_DEF];
    logic signed [WORD_W-1:0] hist_y2    [NUM_CHANNELS_DEF];
    logic [RAW_W-1:0]         step_level [NUM_CHANNELS_DEF];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int errors         = 0;
    int samples_queued = 0;
    int samples_sent   = 0;
    int results_seen   = 0;
    int zero_results   = 0;
    int full_results   = 0;
    int cfg_writes     = 0;
    int cycle_count    = 0;

    calibrated_biquad_lowpass_4ch DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
    end

    function automatic logic signed [WORD_W-1:0] clamp_word(input longint v);
        if (v > WORD_MAX) return WORD_MAX[WORD_W-1:0];
        if (v < WORD_MIN) return WORD_MIN[WORD_W-1:0];
        return v[WORD_W-1:0];
    endfunction

    // Calibrate, run one biquad step and advance that channel's history
    function automatic logic [OUT_W-1:0] filter_sample(input logic [CH_W-1:0] ch,
                                                        input logic [RAW_W-1:0] raw);
        logic signed [WORD_W-1:0] x;
        logic signed [WORD_W-1:0] y;
        longint                   acc;
        longint                   tenths;
        x = clamp_word(longint'(raw) * longint'(cal_gain[ch]) + longint'(cal_offset[ch]));
        acc = FILT_COEF[COEF_SET][TAP_X0] * longint'(x)
            + FILT_COEF[COEF_SET][TAP_X1] * longint'(hist_x1[ch])
            + FILT_COEF[COEF_SET][TAP_X2] * longint'(hist_x2[ch])
            - FILT_COEF[COEF_SET][TAP_Y1] * longint'(hist_y1[ch])
            - FILT_COEF[COEF_SET][TAP_Y2] * longint'(hist_y2[ch]);
        y = clamp_word(acc >>> COEF_SHIFT);
        hist_x2[ch] = hist_x1[ch];
        hist_x1[ch] = x;
        hist_y2[ch] = hist_y1[ch];
        hist_y1[ch] = y;
        tenths = longint'(y) * 10;
        if (tenths <= 0) return '0;
        tenths = tenths >>> FRAC_BITS;
        if (tenths > TENTHS_MAX) return '1;
        return tenths[OUT_W-1:0];
    endfunction

    // Sample driver: predict on each accepted request, then offer the next one
    always @(posedge i_clk) begin
        t_sample          nxt;
        logic [OUT_W-1:0] want;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                want = filter_sample(s_axis_tuser, s_axis_tdata[RAW_W-1:0]);
                tenths_q.push_back('{s_axis_tuser, want});
                samples_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = sample_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.word;
                    s_axis_tuser  <= nxt.channel;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_tenths want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (tenths_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result channel=%0d tenths=%0d",
                             $time, m_axis_tuser, m_axis_tdata);
                end else begin
                    want = tenths_q.pop_front();
                    if (m_axis_tuser !== want.channel) begin
                        errors++;
                        $display("%0t: channel mismatch expected=%0d actual=%0d",
                                 $time, want.channel, m_axis_tuser);
                    end
                    if (m_axis_tdata !== want.tenths) begin
                        errors++;
                        $display("%0t: tenths mismatch on channel %0d expected=%0d actual=%0d",
                                 $time, want.channel, want.tenths, m_axis_tdata);
                    end
                    if (want.tenths == '0) zero_results++;
                    if (want.tenths == '1) full_results++;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Every queued request accepted and every expected result returned
    task automatic wait_idle();
        while (samples_sent != samples_queued || tenths_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Call at a rising edge; returns at a rising edge with the channel idle
    task automatic write_cal_reg(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [WORD_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx < CFG_REG_COUNT) begin
            if (idx[0]) cal_offset[idx[CH_W:1]] = val;
            else        cal_gain[idx[CH_W:1]]   = val;
        end
        cfg_writes++;
        @(posedge i_clk);
    endtask

    task automatic load_channel_cal(input int ch, input logic [WORD_W-1:0] gain,
                                    input logic [WORD_W-1:0] offset);
        write_cal_reg(CFG_IDX_W'(REG_GAIN_CH0 + 2 * ch), gain);
        write_cal_reg(CFG_IDX_W'(REG_OFFSET_CH0 + 2 * ch), offset);
    endtask

    task automatic queue_sample(input int ch, input logic [RAW_W-1:0] raw,
                                input logic [PAD_W-1:0] pad);
        t_sample s;
        s.channel = CH_W'(ch);
        s.word    = {pad, raw};
        sample_q.push_back(s);
        samples_queued++;
    endtask

    // Mix of held levels (to settle the filter), rail values and noise
    task automatic queue_random_samples(input int n);
        int               k;
        int               ch;
        logic [RAW_W-1:0] raw;
        logic [PAD_W-1:0] pad;
        for (k = 0; k < n; k++) begin
            ch = $urandom_range(NUM_CHANNELS_DEF - 1);
            case ($urandom_range(9))
                0:          raw = '0;
                1:          raw = '1;
                2, 3, 4, 5: raw = step_level[ch];
                default:    raw = RAW_W'($urandom());
            endcase
            if ($urandom_range(19) == 0) step_level[ch] = RAW_W'($urandom());
            pad = ($urandom_range(3) == 0) ? PAD_W'($urandom()) : '0;
            queue_sample(ch, raw, pad);
        end
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, tenths_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int               p;
        int               c;
        logic [WORD_W-1:0] g;
        logic [WORD_W-1:0] o;
        for (c = 0; c < CAL_CHANNELS; c++) begin
            cal_gain[c]   = GAIN_RESET;
            cal_offset[c] = '0;
        end
        for (c = 0; c < NUM_CHANNELS_DEF; c++) begin
            hist_x1[c]    = '0;
            hist_x2[c]    = '0;
            hist_y1[c]    = '0;
            hist_y2[c]    = '0;
            step_level[c] = RAW_W'($urandom());
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset calibration, full-scale steps, padding bits set
        for (c = 0; c < NUM_CHANNELS_DEF; c++) begin
            queue_sample(c, '1, '0);
            queue_sample(c, '1, '1);
            queue_sample(c, '0, '0);
        end
        wait_idle();

        // Directed: extreme calibration, saturation both ways, dropped indexes
        load_channel_cal(0, WORD_MAX[WORD_W-1:0], WORD_MAX[WORD_W-1:0]);
        load_channel_cal(1, WORD_MIN[WORD_W-1:0], WORD_MIN[WORD_W-1:0]);
        load_channel_cal(2, '0, WORD_MAX[WORD_W-1:0]);
        load_channel_cal(3, -GAIN_RESET, '0);
        write_cal_reg(REG_UNMAPPED, $urandom());
        write_cal_reg('1, $urandom());
        for (c = 0; c < NUM_CHANNELS_DEF; c++) begin
            queue_sample(c, '1, '0);
            queue_sample(c, '0, '1);
            queue_sample(c, '1, '0);
        end
        wait_idle();

        for (p = 0; p < NUM_PHASES; p++) begin
            case (p % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            for (c = 0; c < CAL_CHANNELS; c++) begin
                case (p % 3)
                    0: begin
                        g = $urandom_range(6 * 65536) - 2 * 65536;
                        o = $urandom_range(1 << 26) - (1 << 25);
                    end
                    1: begin
                        g = $urandom();
                        o = $urandom();
                    end
                    default: begin
                        g = (c == 2) ? 16 * GAIN_RESET : GAIN_RESET;
                        o = (c == 3) ? -(2048 * 65536) : 0;
                    end
                endcase
                load_channel_cal(c, g, o);
            end
            write_cal_reg(CFG_IDX_W'(REG_UNMAPPED + $urandom_range(CFG_REG_COUNT - 1)),
                          $urandom());
            // hold the sender halfway until every result is back
            queue_random_samples(PHASE_ITEMS / 2);
            wait_idle();
            queue_random_samples(PHASE_ITEMS / 2);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d samples on %0d channels, %0d register writes, %0d phases",
                 samples_sent, NUM_CHANNELS_DEF, cfg_writes, NUM_PHASES);
        $display("checked %0d results: %0d clamped at zero, %0d at full scale, %0d errors",
                 results_seen, zero_results, full_results, errors);
        if (errors == 0 && tenths_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
